[rtl/adagrad_weight_update_assert.svh]
// assertion macros used by the adagrad weight update controller
// no dependencies; bodies compile away when SYNTH is defined
`ifndef ADAGRAD_WEIGHT_UPDATE_ASSERT_SVH
`define ADAGRAD_WEIGHT_UPDATE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define AWU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awu same-cycle check failed");
// next-cycle implication
`define AWU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awu next-cycle check failed");
`else
`define AWU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AWU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/awu_pkg.sv]
// shared constants, command and status types for the adagrad weight update
// no dependencies
`default_nettype none

package awu_pkg;

  localparam int NUM_WEIGHTS = 4096;
  localparam int IDX_W       = $clog2(NUM_WEIGHTS);
  localparam int CNT_W       = (IDX_W > 7) ? IDX_W : 7;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_RATE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_RATE     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 8'd4;

  localparam logic [31:0] LEARN_RATE_RST  = 32'd655;
  localparam logic [31:0] EPSILON_RST     = 32'd1;
  localparam logic [15:0] BATCH_COUNT_RST = 16'd1;

  // iteration counts of the shared units
  localparam int MUL_STEPS  = 5;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  // products formed by the shared multiplier, in issue order
  typedef enum logic [2:0] {
    P_L1D   = 3'd0,
    P_L2D   = 3'd1,
    P_WSQ   = 3'd2,
    P_L1INC = 3'd3,
    P_L2INC = 3'd4,
    P_L2MAG = 3'd5,
    P_GSQ   = 3'd6,
    P_LRG   = 3'd7
  } prod_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_CAPTURE    = 4'd1,
    OP_CLEAR      = 4'd2,
    OP_MUL_LOAD   = 4'd3,
    OP_MUL_STEP   = 4'd4,
    OP_MUL_STORE  = 4'd5,
    OP_SUM        = 4'd6,
    OP_DIV_G_LOAD = 4'd7,
    OP_DIV_STEP   = 4'd8,
    OP_G_SAT      = 4'd9,
    OP_ACCUM      = 4'd10,
    OP_SQRT_STEP  = 4'd11,
    OP_DIV_Q_LOAD = 4'd12,
    OP_FINISH     = 4'd13
  } op_t;

  typedef struct packed {
    op_t              op;
    prod_t            prod;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic root_zero;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/awu_if.sv]
// request channels of the adagrad weight update: item, result, configuration
// depends on awu_pkg
`default_nettype none

interface awu_item_if;
  logic                         valid;
  logic                         ready;
  logic [awu_pkg::IDX_W-1:0]    elem_index;
  logic signed [31:0]           weight_in;
  logic signed [31:0]           grad_in;
  logic [15:0]                  l1_mult;
  logic [15:0]                  l2_mult;
  modport source (output valid, elem_index, weight_in, grad_in, l1_mult, l2_mult,
                  input ready);
  modport sink (input valid, elem_index, weight_in, grad_in, l1_mult, l2_mult,
                output ready);
endinterface

interface awu_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight_out;
  logic [63:0]        l1_loss_total;
  logic [63:0]        l2_loss_total;
  modport source (output valid, weight_out, l1_loss_total, l2_loss_total, input ready);
  modport sink (input valid, weight_out, l1_loss_total, l2_loss_total, output ready);
endinterface

interface awu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [awu_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [awu_pkg::CFG_DATA_W-1:0]    wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

[rtl/adagrad_weight_update.sv]
// Adagrad update with L1/L2 decay: one request in, one result out.
// The work is two passes through the shared 64-step divider (one when the root is zero),
// a 32-step root and eight multiplies.
// One request at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous; a clearing pass over all 4096 entries zeroes the squared-gradient store
// while requests are held off; configuration writes are taken at all times outside reset.
`default_nettype none

module adagrad_weight_update (
  input  logic          clk,
  input  logic          rst,
  awu_item_if.sink      item,
  awu_result_if.source  result,
  awu_cfg_if.sink       cfg
);

  awu_pkg::dp_cmd_t cmd;
  awu_pkg::dp_sts_t sts;

  // sequencer
  awu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic and storage
  awu_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .elem_index (item.elem_index),
    .weight_in  (item.weight_in),
    .grad_in    (item.grad_in),
    .l1_mult    (item.l1_mult),
    .l2_mult    (item.l2_mult),
    .cfg        (cfg),
    .result     (result)
  );

endmodule

`default_nettype wire

[rtl/awu_dpath.sv]
// datapath: config registers, shared multiplier, divider, square root,
// squared-gradient memory and result register; depends on awu_pkg, awu_if
`default_nettype none

module awu_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  awu_pkg::dp_cmd_t          cmd,
  output awu_pkg::dp_sts_t          sts,
  input  logic [awu_pkg::IDX_W-1:0] elem_index,
  input  logic [31:0]               weight_in,
  input  logic [31:0]               grad_in,
  input  logic [15:0]               l1_mult,
  input  logic [15:0]               l2_mult,
  awu_cfg_if.sink                   cfg,
  awu_result_if.source              result
);

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  localparam logic [63:0] G_NEG_MAX = 64'h0000_0000_8000_0000;
  localparam logic [63:0] G_POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [33:0] Q_MAX     = 34'h2_0000_0000;

  // configuration registers
  logic [31:0] learn_rate, epsilon, l1_rate, l2_rate;
  logic [15:0] batch_count;

  // captured request
  logic [awu_pkg::IDX_W-1:0] idx_r;
  logic [31:0] w_r, grad_r;
  logic [15:0] l1m_r, l2m_r;

  // intermediate values
  logic [39:0] l1d, l2d;
  logic [63:0] wsq, l1inc, l2inc, gsq, lrg, nmag;
  logic [55:0] l2mag;
  logic        num_neg;
  logic [31:0] gmag;
  logic [63:0] l1acc, l2acc;

  // shared multiplier
  logic [63:0]  mul_a, mul_b, pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;

  // shared divider and square root
  logic [63:0] quo;
  logic [31:0] rem, dvs;
  logic [63:0] sv, sr, sbit;

  // squared-gradient memory
  logic [63:0] sq_mem [awu_pkg::NUM_WEIGHTS];
  logic [63:0] sq_rd;
  logic                      mem_we;
  logic [awu_pkg::IDX_W-1:0] mem_wa;
  logic [63:0]               mem_wd;

  // result register
  logic        out_valid;
  logic [31:0] out_w;
  logic [63:0] out_l1, out_l2;

  // comb helpers
  logic [31:0]  wmag;
  logic         wneg, wpos;
  logic [31:0]  a_part, b_part;
  logic [1:0]   pp_pos;
  logic [127:0] acc_add;
  logic [63:0]  l2_term, l1_term, grad_ext, num;
  logic [32:0]  div_t, div_diff;
  logic         div_ge;
  logic [63:0]  sq_trial, sq_new;
  logic [33:0]  q;
  logic [35:0]  w36, q36, nw;
  logic [31:0]  nw_sat;

  assign wneg = w_r[31];
  assign wpos = !w_r[31] && (w_r != 32'd0);
  assign wmag = w_r[31] ? (~w_r + 32'd1) : w_r;

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate  <= awu_pkg::LEARN_RATE_RST;
      epsilon     <= awu_pkg::EPSILON_RST;
      l1_rate     <= 32'd0;
      l2_rate     <= 32'd0;
      batch_count <= awu_pkg::BATCH_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        awu_pkg::REG_LEARN_RATE:  learn_rate  <= cfg.wr_data;
        awu_pkg::REG_EPSILON:     epsilon     <= cfg.wr_data;
        awu_pkg::REG_L1_RATE:     l1_rate     <= cfg.wr_data;
        awu_pkg::REG_L2_RATE:     l2_rate     <= cfg.wr_data;
        awu_pkg::REG_BATCH_COUNT: batch_count <= cfg.wr_data[15:0];
        default: ;
      endcase
    end
  end

  // multiplier partial product select and shifted accumulate
  assign a_part  = cmd.cnt[0] ? mul_a[63:32] : mul_a[31:0];
  assign b_part  = cmd.cnt[1] ? mul_b[63:32] : mul_b[31:0];
  assign pp_pos  = {1'b0, pp_sh[0]} + {1'b0, pp_sh[1]};
  assign acc_add = {64'd0, pp} << {pp_pos, 5'd0};

  // signed gradient sum
  assign grad_ext = {{32{grad_r[31]}}, grad_r};
  assign l2_term  = wneg ? (~{8'd0, l2mag} + 64'd1) : {8'd0, l2mag};
  assign l1_term  = wpos ? {24'd0, l1d} : (~{24'd0, l1d} + 64'd1);
  assign num      = grad_ext + l2_term + l1_term;

  // restoring divider step
  assign div_t    = {rem, quo[63]};
  assign div_ge   = div_t >= {1'b0, dvs};
  assign div_diff = div_t - {1'b0, dvs};

  // store update and root trial
  assign sq_new   = sat_add64(sq_rd, gsq);
  assign sq_trial = sr + sbit;

  // final step and weight saturation
  always_comb begin
    if (sr == 64'd0) begin
      q = 34'd0;
    end else if ((quo[63:34] != 30'd0) || (quo[33:0] > Q_MAX)) begin
      q = Q_MAX;
    end else begin
      q = quo[33:0];
    end
    w36 = {{4{w_r[31]}}, w_r};
    q36 = {2'b00, q};
    nw  = num_neg ? (w36 + q36) : (w36 - q36);
    if (nw[35] && (nw[35:31] != 5'b11111)) begin
      nw_sat = 32'h8000_0000;
    end else if (!nw[35] && (nw[35:31] != 5'b00000)) begin
      nw_sat = 32'h7FFF_FFFF;
    end else begin
      nw_sat = nw[31:0];
    end
  end

  // sequenced datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      awu_pkg::OP_CAPTURE: begin
        idx_r  <= elem_index;
        w_r    <= weight_in;
        grad_r <= grad_in;
        l1m_r  <= l1_mult;
        l2m_r  <= l2_mult;
      end
      awu_pkg::OP_MUL_LOAD: begin
        acc <= 128'd0;
        case (cmd.prod)
          awu_pkg::P_L1D:   begin mul_a <= {32'd0, l1_rate};    mul_b <= {48'd0, l1m_r}; end
          awu_pkg::P_L2D:   begin mul_a <= {32'd0, l2_rate};    mul_b <= {48'd0, l2m_r}; end
          awu_pkg::P_WSQ:   begin mul_a <= {32'd0, wmag};       mul_b <= {32'd0, wmag};  end
          awu_pkg::P_L1INC: begin mul_a <= {24'd0, l1d};        mul_b <= {32'd0, wmag};  end
          awu_pkg::P_L2INC: begin mul_a <= {24'd0, l2d};        mul_b <= wsq;            end
          awu_pkg::P_L2MAG: begin mul_a <= {24'd0, l2d};        mul_b <= {32'd0, wmag};  end
          awu_pkg::P_GSQ:   begin mul_a <= {32'd0, gmag};       mul_b <= {32'd0, gmag};  end
          awu_pkg::P_LRG:   begin mul_a <= {32'd0, learn_rate}; mul_b <= {32'd0, gmag};  end
          default: ;
        endcase
      end
      awu_pkg::OP_MUL_STEP: begin
        // issue a partial product and add the one issued on the previous step
        if (cmd.cnt[2:0] != 3'(awu_pkg::MUL_STEPS - 1)) begin
          pp    <= 64'(a_part) * 64'(b_part);
          pp_sh <= cmd.cnt[1:0];
        end
        if (cmd.cnt[2:0] != 3'd0) begin
          acc <= acc + acc_add;
        end
      end
      awu_pkg::OP_MUL_STORE: begin
        case (cmd.prod)
          awu_pkg::P_L1D:   l1d   <= acc[47:8];
          awu_pkg::P_L2D:   l2d   <= acc[47:8];
          awu_pkg::P_WSQ:   wsq   <= acc[63:0];
          awu_pkg::P_L1INC: l1inc <= (acc[127:64] != 64'd0) ? {64{1'b1}} : acc[63:0];
          awu_pkg::P_L2INC: l2inc <= (acc[127:81] != 47'd0) ? {64{1'b1}} : acc[80:17];
          awu_pkg::P_L2MAG: l2mag <= acc[71:16];
          awu_pkg::P_GSQ:   gsq   <= acc[63:0];
          awu_pkg::P_LRG:   lrg   <= acc[63:0];
          default: ;
        endcase
      end
      awu_pkg::OP_SUM: begin
        num_neg <= num[63];
        nmag    <= num[63] ? (~num + 64'd1) : num;
      end
      awu_pkg::OP_DIV_G_LOAD: begin
        quo <= nmag;
        rem <= 32'd0;
        dvs <= (batch_count == 16'd0) ? 32'd1 : {16'd0, batch_count};
      end
      awu_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? div_diff[31:0] : div_t[31:0];
        quo <= {quo[62:0], div_ge};
      end
      awu_pkg::OP_G_SAT: begin
        if (num_neg) begin
          gmag <= (quo > G_NEG_MAX) ? G_NEG_MAX[31:0] : quo[31:0];
        end else begin
          gmag <= (quo > G_POS_MAX) ? G_POS_MAX[31:0] : quo[31:0];
        end
      end
      awu_pkg::OP_ACCUM: begin
        sv   <= sat_add64(sq_new, {16'd0, epsilon, 16'd0});
        sr   <= 64'd0;
        sbit <= 64'h4000_0000_0000_0000;
      end
      awu_pkg::OP_SQRT_STEP: begin
        if (sv >= sq_trial) begin
          sv <= sv - sq_trial;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      awu_pkg::OP_DIV_Q_LOAD: begin
        quo <= lrg;
        rem <= 32'd0;
        dvs <= sr[31:0];
      end
      default: ;
    endcase
  end

  // decay loss totals, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      l1acc <= 64'd0;
      l2acc <= 64'd0;
    end else if (cmd.op == awu_pkg::OP_SUM) begin
      l1acc <= sat_add64(l1acc, l1inc);
      l2acc <= sat_add64(l2acc, l2inc);
    end
  end

  // squared-gradient memory: clearing pass and read-modify-write
  assign mem_we = (cmd.op == awu_pkg::OP_CLEAR) || (cmd.op == awu_pkg::OP_ACCUM);
  assign mem_wa = (cmd.op == awu_pkg::OP_CLEAR) ? cmd.cnt[awu_pkg::IDX_W-1:0] : idx_r;
  assign mem_wd = (cmd.op == awu_pkg::OP_CLEAR) ? 64'd0 : sq_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sq_mem[mem_wa] <= mem_wd;
    end
    sq_rd <= sq_mem[idx_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == awu_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == awu_pkg::OP_FINISH) begin
      out_w  <= nw_sat;
      out_l1 <= l1acc;
      out_l2 <= l2acc;
    end
  end

  assign result.valid         = out_valid;
  assign result.weight_out    = out_w;
  assign result.l1_loss_total = out_l1;
  assign result.l2_loss_total = out_l2;

  assign sts.root_zero = (sr == 64'd0);
  assign sts.out_free  = !out_valid || result.ready;

endmodule

`default_nettype wire

[rtl/awu_ctrl.sv]
// controller: clearing pass, request accept and sequencing of the datapath
// depends on awu_pkg and the assertion macro header
`default_nettype none
`include "adagrad_weight_update_assert.svh"

module awu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  awu_pkg::dp_sts_t  sts,
  output awu_pkg::dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_MUL_LD   = 14'b00000000000100,
    S_MUL_RUN  = 14'b00000000001000,
    S_MUL_ST   = 14'b00000000010000,
    S_SUM      = 14'b00000000100000,
    S_DIV_G_LD = 14'b00000001000000,
    S_DIV_G    = 14'b00000010000000,
    S_G_SAT    = 14'b00000100000000,
    S_ACCUM    = 14'b00001000000000,
    S_SQRT     = 14'b00010000000000,
    S_DIV_Q_LD = 14'b00100000000000,
    S_DIV_Q    = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  localparam logic [awu_pkg::CNT_W-1:0] CLR_LAST  = awu_pkg::CNT_W'(awu_pkg::NUM_WEIGHTS - 1);
  localparam logic [awu_pkg::CNT_W-1:0] MUL_LAST  = awu_pkg::CNT_W'(awu_pkg::MUL_STEPS - 1);
  localparam logic [awu_pkg::CNT_W-1:0] DIV_LAST  = awu_pkg::CNT_W'(awu_pkg::DIV_STEPS - 1);
  localparam logic [awu_pkg::CNT_W-1:0] SQRT_LAST = awu_pkg::CNT_W'(awu_pkg::SQRT_STEPS - 1);

  state_t                    state, state_next;
  logic [awu_pkg::CNT_W-1:0] cnt, cnt_next;
  awu_pkg::prod_t            pidx, pidx_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      pidx  <= awu_pkg::P_L1D;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pidx  <= pidx_next;
    end
  end

  // sequencing
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pidx_next  = pidx;
    item_ready = 1'b0;
    cmd.op     = awu_pkg::OP_NOP;
    cmd.prod   = pidx;
    cmd.cnt    = cnt;
    case (state)
      S_CLEAR: begin
        cmd.op = awu_pkg::OP_CLEAR;
        if (cnt == CLR_LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op     = awu_pkg::OP_CAPTURE;
          pidx_next  = awu_pkg::P_L1D;
          state_next = S_MUL_LD;
        end
      end
      S_MUL_LD: begin
        cmd.op     = awu_pkg::OP_MUL_LOAD;
        cnt_next   = '0;
        state_next = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd.op = awu_pkg::OP_MUL_STEP;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_MUL_ST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MUL_ST: begin
        cmd.op    = awu_pkg::OP_MUL_STORE;
        pidx_next = awu_pkg::prod_t'(pidx + 3'd1);
        if (pidx == awu_pkg::P_L2MAG) begin
          state_next = S_SUM;
        end else if (pidx == awu_pkg::P_LRG) begin
          state_next = S_ACCUM;
        end else begin
          state_next = S_MUL_LD;
        end
      end
      S_SUM: begin
        cmd.op     = awu_pkg::OP_SUM;
        state_next = S_DIV_G_LD;
      end
      S_DIV_G_LD: begin
        cmd.op     = awu_pkg::OP_DIV_G_LOAD;
        cnt_next   = '0;
        state_next = S_DIV_G;
      end
      S_DIV_G: begin
        cmd.op = awu_pkg::OP_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_G_SAT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_G_SAT: begin
        cmd.op     = awu_pkg::OP_G_SAT;
        state_next = S_MUL_LD;
      end
      S_ACCUM: begin
        cmd.op     = awu_pkg::OP_ACCUM;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = awu_pkg::OP_SQRT_STEP;
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_DIV_Q_LD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV_Q_LD: begin
        // a zero root means a zero step: skip the division
        if (sts.root_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = awu_pkg::OP_DIV_Q_LOAD;
          cnt_next   = '0;
          state_next = S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        cmd.op = awu_pkg::OP_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op     = awu_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  // checks
  `AWU_ASSERT_NXT(a_accept_starts, clk, rst, (state == S_IDLE) && item_valid, state == S_MUL_LD)
  `AWU_ASSERT_IMP(a_finish_free, clk, rst, cmd.op == awu_pkg::OP_FINISH, sts.out_free)
  `AWU_ASSERT_IMP(a_sum_after_six, clk, rst, state == S_SUM, pidx == awu_pkg::P_GSQ)
  `AWU_ASSERT_NXT(a_clear_ends, clk, rst, (state == S_CLEAR) && (cnt == CLR_LAST), state == S_IDLE)

endmodule

`default_nettype wire
